// File: rtl/hash_table_double_rehash_assert.svh
// assertion macros for the hash table rehash block
`ifndef HASH_TABLE_DOUBLE_REHASH_ASSERT_SVH
`define HASH_TABLE_DOUBLE_REHASH_ASSERT_SVH

// same-cycle implication, checked outside reset
`define HTDR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define HTDR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/htdr_pkg.sv
// shared constants and types for the hash table rehash block
package htdr_pkg;

	// table geometry
	localparam int OLD_DEPTH = 256;
	localparam int OLD_AW    = $clog2(OLD_DEPTH);
	localparam int NEW_DEPTH = 2 * OLD_DEPTH;
	localparam int NEW_AW    = OLD_AW + 1;
	localparam int CNT_W     = OLD_AW + 1;

	// field widths
	localparam int KEY_W  = 31;
	localparam int SLOT_W = 9;
	localparam int SIZE_W = 9;
	localparam int OP_W   = 2;
	localparam int MOD_CW = $clog2(KEY_W + 1);

	// hash mix constant
	localparam logic [KEY_W-1:0] HASH_XOR = KEY_W'(2);

	// command codes
	localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
	localparam logic [OP_W-1:0] OP_REHASH = 2'd1;
	localparam logic [OP_W-1:0] OP_READ   = 2'd2;

	// remainder unit request and response
	typedef struct packed {
		logic              start;
		logic [KEY_W-1:0]  dividend;
		logic [NEW_AW:0]   divisor;
	} mod_req_t;

	typedef struct packed {
		logic              done;
		logic [NEW_AW-1:0] rem;
	} mod_rsp_t;

endpackage

// File: rtl/htdr_mod.sv
// bit-serial remainder unit: hash value modulo the new table size
module htdr_mod (
	input  logic              clk,
	input  logic              arst_n,
	input  htdr_pkg::mod_req_t req,
	output htdr_pkg::mod_rsp_t rsp
);

	logic [htdr_pkg::KEY_W-1:0]  div_q;
	logic [htdr_pkg::NEW_AW:0]   dvs_q;
	logic [htdr_pkg::NEW_AW-1:0] rem_q;
	logic [htdr_pkg::MOD_CW-1:0] cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [htdr_pkg::NEW_AW:0]   trial;
	logic [htdr_pkg::NEW_AW-1:0] rem_nxt;

	// one restoring step: bring down the next dividend bit
	always_comb begin
		trial = {rem_q, div_q[htdr_pkg::KEY_W-1]};
		if (trial >= dvs_q) begin
			rem_nxt = htdr_pkg::NEW_AW'(trial - dvs_q);
		end else begin
			rem_nxt = trial[htdr_pkg::NEW_AW-1:0];
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= htdr_pkg::MOD_CW'(htdr_pkg::KEY_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == htdr_pkg::MOD_CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			div_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			div_q <= {div_q[htdr_pkg::KEY_W-2:0], 1'b0};
			rem_q <= rem_nxt;
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

endmodule

// File: rtl/hash_table_double_rehash.sv
// Slot write: result is registered in the output register; one write per cycle while out_stall allows.
// Slot read: new table data is registered, then the result; no new command is taken meanwhile.
// Rehash: clear of all 512 new-table slots, then two passes over the old slots; a slot whose
// key goes to the 31-step remainder unit waits for it, and pass two then probes linearly.
// Reset: in_stall stays high during a clear of all 512 new-table slots; old table is unset.
module hash_table_double_rehash (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [htdr_pkg::SIZE_W-1:0] cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [htdr_pkg::OP_W-1:0]   opcode,
	input  logic [htdr_pkg::SLOT_W-1:0] slot_index,
	input  logic                        slot_used,
	input  logic [htdr_pkg::KEY_W-1:0]  key_in,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        out_used,
	output logic [htdr_pkg::KEY_W-1:0]  key_out,
	output logic                        done_res
);

	`include "hash_table_double_rehash_assert.svh"

	localparam logic [3:0] ST_CLR      = 4'd0;
	localparam logic [3:0] ST_IDLE     = 4'd1;
	localparam logic [3:0] ST_RD       = 4'd2;
	localparam logic [3:0] ST_RESP     = 4'd3;
	localparam logic [3:0] ST_P1_RD    = 4'd4;
	localparam logic [3:0] ST_P1_OLD   = 4'd5;
	localparam logic [3:0] ST_P1_MODW  = 4'd6;
	localparam logic [3:0] ST_P1_NEW   = 4'd7;
	localparam logic [3:0] ST_P2_RD    = 4'd8;
	localparam logic [3:0] ST_P2_OLD   = 4'd9;
	localparam logic [3:0] ST_P2_MODW  = 4'd10;
	localparam logic [3:0] ST_P2_PROBE = 4'd11;

	localparam int ENT_W = htdr_pkg::KEY_W + 1;

	logic [3:0]                  state_q, state_d;
	logic [htdr_pkg::SIZE_W-1:0] old_size_q;
	logic [htdr_pkg::CNT_W-1:0]  idx_q, idx_d;
	logic [htdr_pkg::NEW_AW-1:0] clr_q, clr_d;
	logic                        rh_q, rh_d;
	logic [htdr_pkg::KEY_W-1:0]  key_q, key_d;
	logic [htdr_pkg::NEW_AW-1:0] s_q, s_d;
	logic [htdr_pkg::NEW_AW:0]   probe_q, probe_d;

	logic [htdr_pkg::CNT_W-1:0]  osize;
	logic [htdr_pkg::NEW_AW:0]   nsize;
	logic                        idx_last;
	logic [htdr_pkg::NEW_AW:0]   s_inc;
	logic [htdr_pkg::NEW_AW-1:0] s_nxt;
	logic                        in_acc;
	logic                        out_free;

	// memories
	logic [ENT_W-1:0]            old_mem [htdr_pkg::OLD_DEPTH];
	logic [ENT_W-1:0]            new_mem [htdr_pkg::NEW_DEPTH];
	logic [ENT_W-1:0]            old_rdata_q, new_rdata_q;
	logic                        old_we, new_we;
	logic [htdr_pkg::OLD_AW-1:0] old_wa, old_ra;
	logic [htdr_pkg::NEW_AW-1:0] new_wa, new_ra;
	logic [ENT_W-1:0]            old_wd, new_wd;

	// remainder unit
	htdr_pkg::mod_req_t mreq;
	htdr_pkg::mod_rsp_t mrsp;

	// result path
	logic                        fin, fin_used, fin_done;
	logic [htdr_pkg::KEY_W-1:0]  fin_key;
	logic                        pend_used_q, pend_done_q;
	logic [htdr_pkg::KEY_W-1:0]  pend_key_q;
	logic                        out_valid_q, out_used_q, out_done_q;
	logic [htdr_pkg::KEY_W-1:0]  out_key_q;

	htdr_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			old_size_q <= htdr_pkg::SIZE_W'(htdr_pkg::OLD_DEPTH);
		end else if (cfg_we) begin
			old_size_q <= cfg_wdata;
		end
	end

	// effective old size and new size
	always_comb begin
		if (old_size_q == '0) begin
			osize = htdr_pkg::CNT_W'(1);
		end else if (32'(old_size_q) > htdr_pkg::OLD_DEPTH) begin
			osize = htdr_pkg::CNT_W'(htdr_pkg::OLD_DEPTH);
		end else begin
			osize = htdr_pkg::CNT_W'(old_size_q);
		end
	end

	assign nsize    = {osize, 1'b0};
	assign idx_last = (idx_q + htdr_pkg::CNT_W'(1)) == osize;
	assign s_inc    = {1'b0, s_q} + 1'b1;
	assign s_nxt    = (s_inc == nsize) ? '0 : s_inc[htdr_pkg::NEW_AW-1:0];

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// sequencer: commands, clear sweep and the two placement passes
	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		clr_d   = clr_q;
		rh_d    = rh_q;
		key_d   = key_q;
		s_d     = s_q;
		probe_d = probe_q;

		old_we = 1'b0;
		old_wa = idx_q[htdr_pkg::OLD_AW-1:0];
		old_wd = '0;
		old_ra = idx_q[htdr_pkg::OLD_AW-1:0];
		new_we = 1'b0;
		new_wa = s_q;
		new_wd = {1'b1, key_q};
		new_ra = s_q;

		mreq.start    = 1'b0;
		mreq.dividend = old_rdata_q[htdr_pkg::KEY_W-1:0] ^ htdr_pkg::HASH_XOR;
		mreq.divisor  = nsize;

		fin      = 1'b0;
		fin_used = 1'b0;
		fin_key  = '0;
		fin_done = 1'b1;

		unique case (state_q)
			ST_CLR: begin
				new_we = 1'b1;
				new_wa = clr_q;
				new_wd = '0;
				clr_d  = clr_q + 1'b1;
				if (clr_q == htdr_pkg::NEW_AW'(htdr_pkg::NEW_DEPTH - 1)) begin
					clr_d = '0;
					if (rh_q) begin
						rh_d    = 1'b0;
						idx_d   = '0;
						state_d = ST_P1_RD;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_IDLE: begin
				if (in_acc) begin
					case (opcode)
						htdr_pkg::OP_WRITE: begin
							if (32'(slot_index) < htdr_pkg::OLD_DEPTH) begin
								old_we = 1'b1;
								old_wa = slot_index[htdr_pkg::OLD_AW-1:0];
								old_wd = {slot_used, slot_used ? key_in : '0};
							end
							fin = 1'b1;
						end
						htdr_pkg::OP_REHASH: begin
							rh_d    = 1'b1;
							clr_d   = '0;
							state_d = ST_CLR;
						end
						htdr_pkg::OP_READ: begin
							new_ra  = slot_index[htdr_pkg::NEW_AW-1:0];
							state_d = ST_RD;
						end
						default: begin
							fin      = 1'b1;
							fin_done = 1'b0;
						end
					endcase
				end
			end
			ST_RD: begin
				fin      = 1'b1;
				fin_used = new_rdata_q[htdr_pkg::KEY_W];
				fin_key  = new_rdata_q[htdr_pkg::KEY_W] ?
					new_rdata_q[htdr_pkg::KEY_W-1:0] : '0;
			end
			ST_RESP: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_P1_RD: begin
				state_d = ST_P1_OLD;
			end
			ST_P1_OLD: begin
				// only keys above zero try their home slot
				if (old_rdata_q[htdr_pkg::KEY_W] && (|old_rdata_q[htdr_pkg::KEY_W-1:0])) begin
					mreq.start = 1'b1;
					key_d      = old_rdata_q[htdr_pkg::KEY_W-1:0];
					state_d    = ST_P1_MODW;
				end else if (idx_last) begin
					idx_d   = '0;
					state_d = ST_P2_RD;
				end else begin
					idx_d   = idx_q + 1'b1;
					state_d = ST_P1_RD;
				end
			end
			ST_P1_MODW: begin
				if (mrsp.done) begin
					s_d     = mrsp.rem;
					new_ra  = mrsp.rem;
					state_d = ST_P1_NEW;
				end
			end
			ST_P1_NEW: begin
				// home slot free: move the key and drop it from the old table
				if (!new_rdata_q[htdr_pkg::KEY_W]) begin
					new_we = 1'b1;
					old_we = 1'b1;
				end
				if (idx_last) begin
					idx_d   = '0;
					state_d = ST_P2_RD;
				end else begin
					idx_d   = idx_q + 1'b1;
					state_d = ST_P1_RD;
				end
			end
			ST_P2_RD: begin
				state_d = ST_P2_OLD;
			end
			ST_P2_OLD: begin
				if (old_rdata_q[htdr_pkg::KEY_W]) begin
					mreq.start = 1'b1;
					key_d      = old_rdata_q[htdr_pkg::KEY_W-1:0];
					state_d    = ST_P2_MODW;
				end else if (idx_last) begin
					fin = 1'b1;
				end else begin
					idx_d   = idx_q + 1'b1;
					state_d = ST_P2_RD;
				end
			end
			ST_P2_MODW: begin
				if (mrsp.done) begin
					s_d     = mrsp.rem;
					new_ra  = mrsp.rem;
					probe_d = (htdr_pkg::NEW_AW + 1)'(1);
					state_d = ST_P2_PROBE;
				end
			end
			ST_P2_PROBE: begin
				// linear probe: one slot per cycle until a free one turns up or every new slot has been tried
				if (!new_rdata_q[htdr_pkg::KEY_W] || (probe_q == nsize)) begin
					new_we = !new_rdata_q[htdr_pkg::KEY_W];
					if (idx_last) begin
						fin = 1'b1;
					end else begin
						idx_d   = idx_q + 1'b1;
						state_d = ST_P2_RD;
					end
				end else begin
					s_d     = s_nxt;
					new_ra  = s_nxt;
					probe_d = probe_q + 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		if (fin) begin
			state_d = out_free ? ST_IDLE : ST_RESP;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			idx_q   <= '0;
			clr_q   <= '0;
			rh_q    <= 1'b0;
			probe_q <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			clr_q   <= clr_d;
			rh_q    <= rh_d;
			probe_q <= probe_d;
		end
	end

	// pass working registers
	always_ff @(posedge clk) begin
		key_q <= key_d;
		s_q   <= s_d;
	end

	// old table memory
	always_ff @(posedge clk) begin
		if (old_we) begin
			old_mem[old_wa] <= old_wd;
		end
		old_rdata_q <= old_mem[old_ra];
	end

	// new table memory
	always_ff @(posedge clk) begin
		if (new_we) begin
			new_mem[new_wa] <= new_wd;
		end
		new_rdata_q <= new_mem[new_ra];
	end

	// pending result while the output register is held
	always_ff @(posedge clk) begin
		if (fin && !out_free) begin
			pend_used_q <= fin_used;
			pend_key_q  <= fin_key;
			pend_done_q <= fin_done;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free && (fin || (state_q == ST_RESP))) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && fin) begin
			out_used_q <= fin_used;
			out_key_q  <= fin_key;
			out_done_q <= fin_done;
		end else if (out_free && (state_q == ST_RESP)) begin
			out_used_q <= pend_used_q;
			out_key_q  <= pend_key_q;
			out_done_q <= pend_done_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_used  = out_used_q;
	assign key_out   = out_key_q;
	assign done_res  = out_done_q;

	// checks
	`HTDR_ASSERT_NOW(a_mod_done_when_waited, mrsp.done, (state_q == ST_P1_MODW) || (state_q == ST_P2_MODW), "remainder done outside a wait state")
	`HTDR_ASSERT_NOW(a_pass_index_in_range, (state_q == ST_P1_RD) || (state_q == ST_P2_RD), idx_q < osize, "pass index beyond old size")
	`HTDR_ASSERT_NOW(a_probe_bounded, state_q == ST_P2_PROBE, (probe_q != '0) && (probe_q <= nsize), "probe count out of bounds")
	`HTDR_ASSERT_NEXT(a_read_takes_memory_cycle, in_acc && (opcode == htdr_pkg::OP_READ), state_q == ST_RD, "read did not wait for the memory")

endmodule

// File: tb/tb_top.sv
// self-checking testbench for the double-size hash table rehash block
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// opcode with no meaning, used as noise
	localparam logic [htdr_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic                       used;
		logic [htdr_pkg::KEY_W-1:0] key;
		logic                       done;
	} result_t;

	typedef enum logic [1:0] {ROW_CFG, ROW_OPEN, ROW_TYPED} row_kind_t;

	// ROW_CFG rows carry the register value in idx
	typedef struct packed {
		row_kind_t                   kind;
		logic [htdr_pkg::OP_W-1:0]   op;
		logic [htdr_pkg::SLOT_W-1:0] idx;
		logic                        used;
		logic [htdr_pkg::KEY_W-1:0]  key;
		result_t                     fixed;
	} cmd_row_t;

	localparam result_t RES_NONE = '{used: 1'b0, key: '0, done: 1'b0};
	localparam result_t RES_DONE = '{used: 1'b0, key: '0, done: 1'b1};
	localparam result_t RES_MAXKEY = '{used: 1'b1, key: 31'h7FFFFFFF, done: 1'b1};

	// directed commands: reads before any rehash, noise, size extremes, collisions
	localparam cmd_row_t DIRECTED [24] = '{
		'{ROW_TYPED, htdr_pkg::OP_READ,   9'd0,   1'b0, 31'd0,        RES_DONE},
		'{ROW_TYPED, htdr_pkg::OP_READ,   9'd511, 1'b1, 31'h7FFFFFFF, RES_DONE},
		'{ROW_TYPED, OP_UNUSED,           9'd511, 1'b1, 31'h7FFFFFFF, RES_NONE},
		'{ROW_TYPED, htdr_pkg::OP_WRITE,  9'd300, 1'b1, 31'd5,        RES_DONE},
		'{ROW_TYPED, htdr_pkg::OP_WRITE,  9'd255, 1'b1, 31'd1,        RES_DONE},
		'{ROW_CFG,   htdr_pkg::OP_WRITE,  9'd0,   1'b0, 31'd0,        RES_NONE},
		'{ROW_TYPED, htdr_pkg::OP_WRITE,  9'd0,   1'b1, 31'h7FFFFFFF, RES_DONE},
		'{ROW_TYPED, htdr_pkg::OP_REHASH, 9'd0,   1'b0, 31'd0,        RES_DONE},
		'{ROW_TYPED, htdr_pkg::OP_READ,   9'd0,   1'b0, 31'd0,        RES_DONE},
		'{ROW_TYPED, htdr_pkg::OP_READ,   9'd1,   1'b0, 31'd0,        RES_MAXKEY},
		'{ROW_CFG,   htdr_pkg::OP_WRITE,  9'd3,   1'b0, 31'd0,        RES_NONE},
		'{ROW_OPEN,  htdr_pkg::OP_WRITE,  9'd0,   1'b1, 31'd0,        RES_NONE},
		'{ROW_OPEN,  htdr_pkg::OP_WRITE,  9'd1,   1'b1, 31'd2,        RES_NONE},
		'{ROW_OPEN,  htdr_pkg::OP_WRITE,  9'd2,   1'b1, 31'd14,       RES_NONE},
		'{ROW_OPEN,  htdr_pkg::OP_REHASH, 9'd0,   1'b0, 31'd0,        RES_NONE},
		'{ROW_OPEN,  htdr_pkg::OP_READ,   9'd0,   1'b0, 31'd0,        RES_NONE},
		'{ROW_OPEN,  htdr_pkg::OP_READ,   9'd1,   1'b0, 31'd0,        RES_NONE},
		'{ROW_OPEN,  htdr_pkg::OP_READ,   9'd2,   1'b0, 31'd0,        RES_NONE},
		'{ROW_OPEN,  htdr_pkg::OP_READ,   9'd5,   1'b0, 31'd0,        RES_NONE},
		'{ROW_OPEN,  htdr_pkg::OP_WRITE,  9'd1,   1'b0, 31'h2AAAAAAA, RES_NONE},
		'{ROW_OPEN,  htdr_pkg::OP_WRITE,  9'd2,   1'b1, 31'h55555555, RES_NONE},
		'{ROW_OPEN,  htdr_pkg::OP_REHASH, 9'd0,   1'b0, 31'd0,        RES_NONE},
		'{ROW_OPEN,  htdr_pkg::OP_READ,   9'd3,   1'b0, 31'd0,        RES_NONE},
		'{ROW_TYPED, htdr_pkg::OP_READ,   9'd511, 1'b0, 31'd0,        RES_DONE}
	};

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_we;
	logic [htdr_pkg::SIZE_W-1:0] cfg_wdata;
	logic                        in_valid;
	logic                        in_stall;
	logic [htdr_pkg::OP_W-1:0]   opcode;
	logic [htdr_pkg::SLOT_W-1:0] slot_index;
	logic                        slot_used;
	logic [htdr_pkg::KEY_W-1:0]  key_in;
	logic                        out_valid;
	logic                        out_stall;
	logic                        out_used;
	logic [htdr_pkg::KEY_W-1:0]  key_out;
	logic                        done_res;

	// predicted table contents and register
	bit                          old_used [htdr_pkg::OLD_DEPTH];
	logic [htdr_pkg::KEY_W-1:0]  old_key [htdr_pkg::OLD_DEPTH];
	bit                          was_written [htdr_pkg::OLD_DEPTH];
	bit                          new_used [htdr_pkg::NEW_DEPTH];
	logic [htdr_pkg::KEY_W-1:0]  new_key [htdr_pkg::NEW_DEPTH];
	logic [htdr_pkg::SIZE_W-1:0] size_reg = htdr_pkg::SIZE_W'(htdr_pkg::OLD_DEPTH);

	result_t slot_results_q [$];
	int      fails = 0;
	int      commands_done = 0;
	bit      calm = 1'b0;

	hash_table_double_rehash dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.opcode     (opcode),
		.slot_index (slot_index),
		.slot_used  (slot_used),
		.key_in     (key_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_used   (out_used),
		.key_out    (key_out),
		.done_res   (done_res)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// old slot count actually used for a register value
	function automatic int unsigned size_in_use(input logic [htdr_pkg::SIZE_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > htdr_pkg::OLD_DEPTH)
			return htdr_pkg::OLD_DEPTH;
		return 32'(v);
	endfunction

	function automatic int unsigned probe_at(input logic [htdr_pkg::KEY_W-1:0] k,
			input int unsigned b, input int unsigned nsz);
		longint unsigned h;
		h = longint'(k ^ htdr_pkg::HASH_XOR) + longint'(b);
		return int'(h % longint'(nsz));
	endfunction

	// clear new table, place keys at home, then linear-probe the rest
	function automatic void rebuild_table();
		int unsigned osz;
		int unsigned nsz;
		int unsigned s;
		osz = size_in_use(size_reg);
		nsz = 2 * osz;
		foreach (new_used[i]) begin
			new_used[i] = 1'b0;
			new_key[i] = '0;
		end
		for (int unsigned i = 0; i < osz; i++) begin
			if (old_used[i] && old_key[i] != 0) begin
				s = probe_at(old_key[i], 0, nsz);
				if (!new_used[s]) begin
					new_used[s] = 1'b1;
					new_key[s] = old_key[i];
					old_used[i] = 1'b0;
					old_key[i] = '0;
				end
			end
		end
		for (int unsigned i = 0; i < osz; i++) begin
			if (old_used[i]) begin
				for (int unsigned b = 0; b < nsz; b++) begin
					s = probe_at(old_key[i], b, nsz);
					if (!new_used[s]) begin
						new_used[s] = 1'b1;
						new_key[s] = old_key[i];
						break;
					end
				end
			end
		end
	endfunction

	// apply one command to the predicted tables, return its result
	function automatic result_t apply_command(input logic [htdr_pkg::OP_W-1:0] op,
			input logic [htdr_pkg::SLOT_W-1:0] idx, input logic used,
			input logic [htdr_pkg::KEY_W-1:0] k);
		result_t r;
		r = RES_NONE;
		case (op)
			htdr_pkg::OP_WRITE: begin
				if (idx < htdr_pkg::OLD_DEPTH) begin
					old_used[idx] = used;
					old_key[idx] = used ? k : '0;
					was_written[idx] = 1'b1;
				end
				r.done = 1'b1;
			end
			htdr_pkg::OP_REHASH: begin
				rebuild_table();
				r.done = 1'b1;
			end
			htdr_pkg::OP_READ: begin
				if (new_used[idx]) begin
					r.used = 1'b1;
					r.key = new_key[idx];
				end
				r.done = 1'b1;
			end
			default: ;
		endcase
		return r;
	endfunction

	// mix of colliding, small, full-width and extreme keys
	function automatic logic [htdr_pkg::KEY_W-1:0] pick_key(input int unsigned eff);
		case ($urandom_range(0, 3))
			0: return htdr_pkg::KEY_W'($urandom_range(0, 2 * eff + 3));
			1: return htdr_pkg::KEY_W'(($urandom_range(0, 999) * 2 * eff
				+ $urandom_range(0, 2 * eff - 1)) ^ 2);
			2: return htdr_pkg::KEY_W'($urandom);
			default: return $urandom_range(0, 1) ? 31'h7FFFFFFF : 31'(1);
		endcase
	endfunction

	// one input transaction; expectation recorded at acceptance
	task automatic post_command(input logic [htdr_pkg::OP_W-1:0] op,
			input logic [htdr_pkg::SLOT_W-1:0] idx, input logic used,
			input logic [htdr_pkg::KEY_W-1:0] k, input bit typed = 1'b0,
			input result_t fixed = RES_NONE);
		result_t want;
		in_valid <= 1'b1;
		opcode <= op;
		slot_index <= idx;
		slot_used <= used;
		key_in <= k;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		want = apply_command(op, idx, used, k);
		if (typed)
			want = fixed;
		slot_results_q.push_back(want);
		if (op != OP_UNUSED && !(op == htdr_pkg::OP_WRITE && idx >= htdr_pkg::OLD_DEPTH))
			commands_done++;
		// idle cycles, each taken at random
		if (!calm) begin
			while ($urandom_range(0, 99) < 27) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
	endtask

	// register write once the block has gone quiet
	task automatic load_size(input logic [htdr_pkg::SIZE_W-1:0] v);
		in_valid <= 1'b0;
		while (slot_results_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		size_reg = v;
	endtask

	// output stall pattern
	always @(posedge clk) begin
		out_stall <= !calm && ($urandom_range(0, 99) < 27);
	end

	// compare each result transaction with the oldest expectation
	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (slot_results_q.size() == 0) begin
				$error("result transaction with no command pending");
				fails++;
			end else begin
				want = slot_results_q.pop_front();
				if (out_used !== want.used) begin
					$error("out_used: expected %0d, got %0d", want.used, out_used);
					fails++;
				end
				if (key_out !== want.key) begin
					$error("key_out: expected %0h, got %0h", want.key, key_out);
					fails++;
				end
				if (done_res !== want.done) begin
					$error("done_res: expected %0d, got %0d", want.done, done_res);
					fails++;
				end
			end
		end
	end

	// stimulus
	initial begin
		cmd_row_t    row;
		int          phase;
		int unsigned setting;
		int unsigned eff;
		int unsigned r;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		opcode = htdr_pkg::OP_WRITE;
		slot_index = '0;
		slot_used = 1'b0;
		key_in = '0;
		out_stall = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed table
		foreach (DIRECTED[i]) begin
			row = DIRECTED[i];
			if (row.kind == ROW_CFG)
				load_size(row.idx);
			else
				post_command(row.op, row.idx, row.used, row.key, row.kind == ROW_TYPED, row.fixed);
		end

		// random phases: fill, writes, rehash, reads
		phase = 0;
		while (commands_done < 680) begin
			case (phase)
				0: setting = 1;
				1: setting = 2;
				2: setting = 511;
				3: setting = 0;
				4: setting = 5;
				5: setting = 300;
				6: setting = 256;
				default: setting = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64)
					: $urandom_range(1, 16);
			endcase
			calm = (phase == 2);
			load_size(htdr_pkg::SIZE_W'(setting));
			eff = size_in_use(htdr_pkg::SIZE_W'(setting));
			for (int unsigned i = 0; i < eff; i++) begin
				if (!was_written[i])
					post_command(htdr_pkg::OP_WRITE, htdr_pkg::SLOT_W'(i),
						1'($urandom_range(0, 1)), pick_key(eff));
			end
			repeat ($urandom_range(1, 20)) begin
				r = $urandom_range(0, 15);
				if (r == 0)
					post_command(OP_UNUSED, htdr_pkg::SLOT_W'($urandom), 1'($urandom),
						htdr_pkg::KEY_W'($urandom));
				else if (r == 1)
					post_command(htdr_pkg::OP_WRITE,
						htdr_pkg::SLOT_W'($urandom_range(256, 511)), 1'($urandom),
						htdr_pkg::KEY_W'($urandom));
				else
					post_command(htdr_pkg::OP_WRITE,
						htdr_pkg::SLOT_W'(r < 4 ? $urandom_range(0, 255)
							: $urandom_range(0, eff - 1)),
						$urandom_range(0, 4) != 0, pick_key(eff));
			end
			// now and then no rehash, or two in a row
			r = $urandom_range(0, 7);
			if (r != 0)
				post_command(htdr_pkg::OP_REHASH, htdr_pkg::SLOT_W'($urandom), 1'($urandom),
					htdr_pkg::KEY_W'($urandom));
			if (r == 1)
				post_command(htdr_pkg::OP_REHASH, htdr_pkg::SLOT_W'($urandom), 1'($urandom),
					htdr_pkg::KEY_W'($urandom));
			repeat ($urandom_range(4, 24)) begin
				r = $urandom_range(0, 9);
				post_command(htdr_pkg::OP_READ,
					htdr_pkg::SLOT_W'(r < 3 ? $urandom_range(0, 511)
						: $urandom_range(0, 2 * eff - 1)),
					1'($urandom), htdr_pkg::KEY_W'($urandom));
			end
			calm = 1'b0;
			phase++;
		end

		// drain
		in_valid <= 1'b0;
		while (slot_results_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (fails == 0)
			$display("PASS hash_table_double_rehash");
		else
			$display("FAIL hash_table_double_rehash");
		$finish;
	end

	// run limit
	initial begin
		#40ms;
		$display("FAIL hash_table_double_rehash");
		$finish;
	end

endmodule
